[sv/capture_period_to_speed_top_assert.svh]
// Assertion macros for the capture period to speed block.
// Every check is clocked on clock and disabled while reset is high.
`ifndef CAPTURE_PERIOD_TO_SPEED_TOP_ASSERT_SVH
`define CAPTURE_PERIOD_TO_SPEED_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Implication checked at every edge outside reset
`define CPTS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Signal must be low at every edge outside reset
`define CPTS_ASSERT_NEVER(lbl, sig, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(sig)) else $error(msg);
`else
`define CPTS_ASSERT(lbl, prop, msg)
`define CPTS_ASSERT_NEVER(lbl, sig, msg)
`endif

`endif

[sv/cpts_pkg.sv]
package cpts_pkg;

   // Timer capture width in use; upper bits of the capture port are ignored
   localparam int CAPTURE_BITS = 32;
   localparam int CAPTURE_PORT_BITS = 32;
   localparam int NUM_BITS = 48;
   localparam int SPEED_BITS = 24;
   localparam int STEP_BITS = $clog2(NUM_BITS);
   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(NUM_BITS - 1);

   // Register file
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS = NUM_BITS;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPEED_NUMERATOR = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_SPEED = CSR_INDEX_BITS'(1);
   localparam logic [SPEED_BITS-1:0] MAX_SPEED_RESET = '1;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;   // capture transaction taken this cycle
      logic step;     // one restoring divide step
      logic publish;  // load the result register
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic div_needed;  // capture seen before and nonzero tick difference
   } status_type;

endpackage

[sv/cpts_ctrl.sv]
module cpts_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  cpts_pkg::status_type status,
   output cpts_pkg::cmd_type    cmd
);
   import cpts_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type             state_ff, state_in;
   logic [STEP_BITS-1:0]  count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Commands to the datapath
   always_comb begin
      cmd.accept  = (state_ff == ST_IDLE) && req_valid;
      cmd.step    = (state_ff == ST_DIVIDE);
      cmd.publish = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);
   end

   // Next state, step counter and result valid
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            count_in = '0;
            if (cmd.accept && status.div_needed) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            count_in = count_ff + STEP_BITS'(1);
            if (count_ff == LAST_STEP) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (cmd.publish) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[sv/cpts_dp.sv]
module cpts_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [cpts_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [cpts_pkg::CSR_DATA_BITS-1:0]     csr_write_data,
   input  logic [cpts_pkg::CAPTURE_PORT_BITS-1:0] req_capture_count,
   input  cpts_pkg::cmd_type                      cmd,
   output cpts_pkg::status_type                   status,
   output logic [cpts_pkg::SPEED_BITS-1:0]        rsp_speed_q16,
   output logic                                   rsp_clamped
);
   import cpts_pkg::*;

   logic [NUM_BITS-1:0]      numerator_ff;
   logic [SPEED_BITS-1:0]    max_speed_ff;
   logic [CAPTURE_BITS-1:0]  prev_ff;
   logic                     seen_ff;
   logic [CAPTURE_BITS-1:0]  divisor_ff;
   logic [CAPTURE_BITS-1:0]  rem_ff, rem_in;
   logic [NUM_BITS-1:0]      quot_ff, quot_in;
   logic [SPEED_BITS-1:0]    speed_ff, speed_in;
   logic                     clamped_ff, clamped_in;

   logic [CAPTURE_BITS-1:0]  now;
   logic [CAPTURE_BITS-1:0]  delta;
   logic [CAPTURE_BITS:0]    partial;
   logic [CAPTURE_BITS:0]    trial;
   logic                     over;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         numerator_ff <= '0;
         max_speed_ff <= MAX_SPEED_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SPEED_NUMERATOR: numerator_ff <= csr_write_data;
            CSR_MAX_SPEED:       max_speed_ff <= csr_write_data[SPEED_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Wrap-around tick difference against the previous capture
   assign now   = req_capture_count[CAPTURE_BITS-1:0];
   assign delta = now - prev_ff;
   assign status.div_needed = seen_ff && (delta != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         seen_ff <= 1'b0;
      end else if (cmd.accept) begin
         prev_ff <= now;
         seen_ff <= 1'b1;
      end
   end

   // Restoring divider, one quotient bit per step, MSB first
   assign partial = {rem_ff, quot_ff[NUM_BITS-1]};
   assign trial   = partial - {1'b0, divisor_ff};

   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (cmd.accept) begin
         rem_in  = '0;
         quot_in = numerator_ff;
      end else if (cmd.step) begin
         if (!trial[CAPTURE_BITS]) begin
            rem_in = trial[CAPTURE_BITS-1:0];
         end else begin
            rem_in = partial[CAPTURE_BITS-1:0];
         end
         quot_in = {quot_ff[NUM_BITS-2:0], ~trial[CAPTURE_BITS]};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         divisor_ff <= delta;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   // Saturate against the limit and load the result register
   assign over = (quot_ff > NUM_BITS'(max_speed_ff));

   always_comb begin
      speed_in   = speed_ff;
      clamped_in = clamped_ff;
      if (cmd.publish) begin
         speed_in   = over ? max_speed_ff : quot_ff[SPEED_BITS-1:0];
         clamped_in = over;
      end
   end

   always_ff @(posedge clock) begin
      speed_ff   <= speed_in;
      clamped_ff <= clamped_in;
   end

   assign rsp_speed_q16 = speed_ff;
   assign rsp_clamped   = clamped_ff;

endmodule

[sv/capture_period_to_speed_top.sv]
// Input-capture tachometer. Each req transaction carries a timer count latched
// at an encoder pulse; the first capture after reset and any capture equal to
// the previous one only update the stored count and give no response. Other
// captures produce one rsp transaction: speed_numerator divided by the
// wrap-around tick difference, saturated at max_speed with rsp_clamped set.
// A capture that needs no divide is not stalled. One that does holds req_stall
// while a bit-serial restoring divider produces one of the 48 quotient bits
// per cycle and until the result register is loaded (later if a previous
// response is still stalled). A finished response may wait on rsp_stall while
// the next capture is taken. The user must write registers through the csr
// port only while no transaction is in flight; the block does not enforce it.
// Index 0 is speed_numerator, index 1 is max_speed, other indexes are ignored.
`include "capture_period_to_speed_top_assert.svh"

module capture_period_to_speed_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [cpts_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [cpts_pkg::CSR_DATA_BITS-1:0]     csr_write_data,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [cpts_pkg::CAPTURE_PORT_BITS-1:0] req_capture_count,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [cpts_pkg::SPEED_BITS-1:0]        rsp_speed_q16,
   output logic                                   rsp_clamped
);
   import cpts_pkg::*;

   cmd_type    cmd;
   status_type status;

   cpts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cpts_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_capture_count (req_capture_count),
      .cmd               (cmd),
      .status            (status),
      .rsp_speed_q16     (rsp_speed_q16),
      .rsp_clamped       (rsp_clamped)
   );

   // A divide starts right after a capture that needs one
   `CPTS_ASSERT(a_div_starts, cmd.accept && status.div_needed |=> cmd.step, "divide did not start")
   // Loading the result register always raises rsp_valid
   `CPTS_ASSERT(a_publish_valid, cmd.publish |=> rsp_valid, "result loaded without rsp_valid")
   // No capture is taken while the divider runs
   `CPTS_ASSERT_NEVER(a_no_accept_in_div, cmd.step && !req_stall, "capture open during divide")

endmodule

[tb/sv/testbench.sv]
module testbench;
   import cpts_pkg::*;

   // No acceptance on either channel for this many cycles means a hang. The longest
   // quiet stretch in a correct run is a drain plus the settle pause.
   localparam int WATCHDOG_LIMIT = 2000;
   // Covers the divide when writing registers and at the end
   localparam int SETTLE_CYCLES  = 64;
   localparam int PHASE_ITEMS    = 186;
   localparam int PHASE_COUNT    = 5;

   typedef struct packed {
      logic [SPEED_BITS-1:0] speed_q16;
      logic                  clamped;
   } speed_reading_type;

   // Predicts speed readings from accepted captures and checks the responses
   class tach_scoreboard;
      logic [NUM_BITS-1:0]     numerator;
      logic [SPEED_BITS-1:0]   max_speed;
      logic [CAPTURE_BITS-1:0] last_capture;
      bit                      capture_seen;
      speed_reading_type       pending_speeds[$];
      int                      mismatches;

      function new();
         numerator    = '0;
         max_speed    = MAX_SPEED_RESET;
         last_capture = '0;
         capture_seen = 1'b0;
         mismatches   = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_BITS-1:0] index,
                                 logic [CSR_DATA_BITS-1:0] data);
         case (index)
            CSR_SPEED_NUMERATOR: numerator = data[NUM_BITS-1:0];
            CSR_MAX_SPEED:       max_speed = data[SPEED_BITS-1:0];
            default: ;  // unused indexes are ignored
         endcase
      endfunction

      // Accepted capture transaction: update the stored count, maybe expect a reading
      function void note_capture(logic [CAPTURE_PORT_BITS-1:0] raw);
         logic [CAPTURE_BITS-1:0] now;
         logic [CAPTURE_BITS-1:0] ticks;
         logic [NUM_BITS-1:0]     quotient;
         speed_reading_type       reading;
         now          = raw[CAPTURE_BITS-1:0];
         ticks        = now - last_capture;  // wraps at the capture width
         last_capture = now;
         if (!capture_seen) begin
            capture_seen = 1'b1;
            return;
         end
         if (ticks == '0)
            return;
         quotient = numerator / NUM_BITS'(ticks);
         if (quotient > NUM_BITS'(max_speed)) begin
            reading.speed_q16 = max_speed;
            reading.clamped   = 1'b1;
         end else begin
            reading.speed_q16 = quotient[SPEED_BITS-1:0];
            reading.clamped   = 1'b0;
         end
         pending_speeds.push_back(reading);
      endfunction

      // Accepted response transaction: compare with the oldest expected reading
      task check_speed(logic [SPEED_BITS-1:0] speed_q16, logic clamped);
         speed_reading_type want;
         if (pending_speeds.size() == 0) begin
            report_mismatch($sformatf("unexpected response speed %h clamped %b",
                                      speed_q16, clamped));
            return;
         end
         want = pending_speeds.pop_front();
         if (speed_q16 !== want.speed_q16)
            report_mismatch($sformatf("speed_q16 %h, expected %h", speed_q16, want.speed_q16));
         if (clamped !== want.clamped)
            report_mismatch($sformatf("clamped %b, expected %b", clamped, want.clamped));
      endtask

      task report_mismatch(string what);
         mismatches++;
         $display("ERROR at %0t: %s", $time, what);
      endtask
   endclass

   logic                         clock;
   logic                         reset;
   logic                         csr_write_enable;
   logic [CSR_INDEX_BITS-1:0]    csr_index;
   logic [CSR_DATA_BITS-1:0]     csr_write_data;
   logic                         req_valid;
   logic                         req_stall;
   logic [CAPTURE_PORT_BITS-1:0] req_capture_count;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic [SPEED_BITS-1:0]        rsp_speed_q16;
   logic                         rsp_clamped;

   tach_scoreboard               tach = new();
   logic [CAPTURE_PORT_BITS-1:0] last_sent = '0;
   bit                           steady_flow = 1'b0;
   int                           hold_left = 0;
   int                           quiet_cycles = 0;

   capture_period_to_speed_top dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_capture_count (req_capture_count),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_speed_q16     (rsp_speed_q16),
      .rsp_clamped       (rsp_clamped)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Idle cycles per transaction; none during a steady-flow stretch
   function automatic int draw_wait();
      return steady_flow ? 0 : $urandom_range(0, 6);
   endfunction

   // Numerator of random magnitude so quotients spread over the whole range
   function automatic logic [NUM_BITS-1:0] random_numerator();
      logic [NUM_BITS-1:0] raw;
      raw = NUM_BITS'({$urandom(), $urandom()});
      return raw >> $urandom_range(0, NUM_BITS - 1);
   endfunction

   function automatic logic [SPEED_BITS-1:0] random_ceiling();
      logic [SPEED_BITS-1:0] raw;
      raw = SPEED_BITS'($urandom());
      return raw >> $urandom_range(0, SPEED_BITS - 1);
   endfunction

   // Tick difference: sometimes zero, otherwise of random bit length
   function automatic logic [CAPTURE_BITS-1:0] random_ticks();
      logic [CAPTURE_BITS-1:0] raw;
      raw = CAPTURE_BITS'($urandom());
      if ($urandom_range(0, 99) < 8)
         return '0;
      return raw >> $urandom_range(0, CAPTURE_BITS - 1);
   endfunction

   // Monitor and watchdog: responses are checked before the capture of the same edge.
   // A stalled valid response counts down the drawn hold.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            tach.check_speed(rsp_speed_q16, rsp_clamped);
            hold_left = draw_wait();
         end else if (rsp_valid && rsp_stall && hold_left > 0) begin
            hold_left--;
         end
         if (req_valid && !req_stall)
            tach.note_capture(req_capture_count);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // Response side: stall each reading for the drawn number of valid cycles
   always @(negedge clock) begin
      if (!reset && hold_left > 0) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // One capture transaction; entered and left on a falling edge
   task automatic send_capture(logic [CAPTURE_PORT_BITS-1:0] value);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_capture_count <= value;
      do @(posedge clock); while (!(req_valid && !req_stall));
      last_sent = value;
      @(negedge clock);
   endtask

   task automatic send_ticks(logic [CAPTURE_BITS-1:0] ticks);
      send_capture(last_sent + CAPTURE_PORT_BITS'(ticks));
   endtask

   // Stop sending and wait for every expected reading
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (tach.pending_speeds.size() != 0);
   endtask

   task automatic write_register(logic [CSR_INDEX_BITS-1:0] index,
                                 logic [CSR_DATA_BITS-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      tach.set_register(index, data);
      @(negedge clock);
   endtask

   // Registers change only with the block idle; unused indexes get junk too
   task automatic apply_settings(logic [NUM_BITS-1:0] numerator,
                                 logic [SPEED_BITS-1:0] ceiling);
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      write_register(CSR_SPEED_NUMERATOR, CSR_DATA_BITS'(numerator));
      write_register(CSR_MAX_SPEED, CSR_DATA_BITS'({$urandom(), ceiling}));
      write_register(CSR_INDEX_BITS'($urandom_range(2, 15)),
                     CSR_DATA_BITS'({$urandom(), $urandom()}));
   endtask

   initial begin
      logic [NUM_BITS-1:0]          numerator;
      logic [SPEED_BITS-1:0]        ceiling;
      logic [CAPTURE_PORT_BITS-1:0] next_capture;

      reset             = 1'b1;
      csr_write_enable  = 1'b0;
      csr_index         = '0;
      csr_write_data    = '0;
      req_valid         = 1'b0;
      req_capture_count = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: first capture only records, zero numerator gives speed 0
      send_capture(32'h0000_0000);
      send_capture(32'h0000_0005);

      // Widest numerator: zero difference, one tick, wrap-around, widest difference
      apply_settings('1, '1);
      send_capture(32'h0000_0005);
      send_capture(32'h0000_0006);
      send_capture(32'hFFFF_FFFF);
      send_capture(32'h0000_0000);
      send_capture(32'hFFFF_FFFF);
      send_capture(32'hAAAA_AAAA);
      send_capture(32'h5555_5555);
      send_capture(32'h5555_5555);

      // Quotient exactly at the limit is not clamped, one above is
      apply_settings(NUM_BITS'(24'h123456) * NUM_BITS'(1000), 24'h123456);
      send_ticks(32'd1000);
      send_ticks(32'd999);
      send_ticks(32'd1001);

      // Zero limit: every nonzero quotient clamps to 0
      apply_settings('1, '0);
      send_ticks(32'd1);
      send_ticks(32'hFFFF_FFFF);
      send_ticks(32'h0001_0000);

      // Random phases, each with its own register settings
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin numerator = random_numerator(); ceiling = '1; end
            1: begin numerator = '1;                 ceiling = random_ceiling(); end
            3: begin numerator = '0;                 ceiling = random_ceiling(); end
            default: begin numerator = random_numerator(); ceiling = random_ceiling(); end
         endcase
         steady_flow = 1'b0;
         apply_settings(numerator, ceiling);
         steady_flow = (phase == 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 4 && n == PHASE_ITEMS / 2)
               wait_drained();
            if ($urandom_range(0, 9) == 0)
               next_capture = $urandom();
            else
               next_capture = last_sent + CAPTURE_PORT_BITS'(random_ticks());
            send_capture(next_capture);
         end
      end

      steady_flow = 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (tach.mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

[files.f]
+incdir+sv
sv/cpts_pkg.sv
sv/cpts_ctrl.sv
sv/cpts_dp.sv
sv/capture_period_to_speed_top.sv
tb/sv/testbench.sv
